// ----- rtl/tst_pkg.sv -----
// Shared types, constants and lookup functions of the source text tokenizer.
package tst_pkg;

	// Parameter defaults and queue depths
	localparam int POSITION_BITS_DEF   = 16;
	localparam int KEYWORD_MAX_LEN_DEF = 8;
	localparam int LOOKAHEAD_DEPTH_DEF = 6;
	localparam int FRONT_DEPTH         = 4;
	localparam int RESULT_DEPTH        = 4;

	// Token kinds with a role of their own
	localparam logic [6:0] K_EOF      = 7'd0;
	localparam logic [6:0] K_NUMBER   = 7'd1;
	localparam logic [6:0] K_SLASH_EQ = 7'd25;
	localparam logic [6:0] K_SLASH    = 7'd26;
	localparam logic [6:0] K_STRING   = 7'd46;
	localparam logic [6:0] K_KEYWORD0 = 7'd47;
	localparam logic [6:0] K_IDENT    = 7'd80;

	// Error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [1:0] ERR_UNTERM_STR = 2'd2;
	localparam logic [1:0] ERR_BAD_SUFFIX = 2'd3;

	// Characters the scanner tests directly
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EQ     = 8'h3D;

	typedef enum logic [3:0] {
		S_IDLE, S_SLASH, S_COMMENT, S_IDENT, S_STRING,
		S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_SUFFIX, S_OP
	} scan_mode_t;

	// One classified source byte
	typedef struct packed {
		logic [7:0] ch;
		logic       dig;
		logic       alp;
		logic       spc;
	} byte_rec_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} op_lead_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] kind;
	} single_t;

	// Operator row: optional doubled char, kind for it (0 = go on to next row),
	// kind with a trailing '=', kind of the bare operator
	typedef struct packed {
		logic       c1v;
		logic [7:0] c1;
		logic [6:0] k1;
		logic [6:0] k2;
		logic [6:0] k0;
	} op_row_t;

	localparam int N_KW  = 33;
	localparam int N_SUF = 12;

	localparam logic [63:0] KW_TEXT [N_KW] = '{
		"as      ", "bool    ", "break   ", "const   ", "continue", "else    ",
		"f32     ", "f64     ", "fn      ", "false   ", "for     ", "i8      ",
		"i16     ", "i32     ", "i64     ", "if      ", "null    ", "print   ",
		"return  ", "str     ", "struct  ", "super   ", "type    ", "true    ",
		"this    ", "u8      ", "u16     ", "u32     ", "u64     ", "usize   ",
		"var     ", "void    ", "while   "
	};
	localparam logic [4:0] KW_LEN [N_KW] = '{
		5'd2, 5'd4, 5'd5, 5'd5, 5'd8, 5'd4, 5'd3, 5'd3, 5'd2, 5'd5, 5'd3,
		5'd2, 5'd3, 5'd3, 5'd3, 5'd2, 5'd4, 5'd5, 5'd6, 5'd3, 5'd6, 5'd5,
		5'd4, 5'd4, 5'd4, 5'd2, 5'd3, 5'd3, 5'd3, 5'd5, 5'd3, 5'd4, 5'd5
	};

	localparam logic [63:0] SUF_TEXT [N_SUF] = '{
		"usize   ", "i16     ", "i32     ", "i64     ", "u16     ", "u32     ",
		"u64     ", "i8      ", "u8      ", "f32     ", "f64     ", "u       "
	};
	localparam logic [2:0] SUF_LEN [N_SUF] = '{
		3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd1
	};
	localparam logic SUF_FRAC [N_SUF] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
	};

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
			(b == 8'h0C) || (b == 8'h0D);
	endfunction

	// Byte that opens a multi-char operator
	function automatic op_lead_t op_lead(input logic [7:0] b);
		op_lead_t r;
		r = '0;
		r.hit = 1'b1;
		case (b)
			"=": r.idx = 4'd0;
			"!": r.idx = 4'd1;
			"&": r.idx = 4'd2;
			"|": r.idx = 4'd3;
			"^": r.idx = 4'd4;
			"+": r.idx = 4'd5;
			"-": r.idx = 4'd6;
			"*": r.idx = 4'd7;
			">": r.idx = 4'd8;
			"<": r.idx = 4'd10;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Single-char tokens
	function automatic single_t single_kind(input logic [7:0] b);
		single_t r;
		r = '0;
		r.hit = 1'b1;
		case (b)
			"@": r.kind = 7'd2;
			"~": r.kind = 7'd8;
			"(": r.kind = 7'd35;
			")": r.kind = 7'd36;
			"[": r.kind = 7'd37;
			"]": r.kind = 7'd38;
			"{": r.kind = 7'd39;
			"}": r.kind = 7'd40;
			";": r.kind = 7'd41;
			",": r.kind = 7'd42;
			":": r.kind = 7'd43;
			".": r.kind = 7'd44;
			"?": r.kind = 7'd45;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic op_row_t op_row(input logic [3:0] idx);
		op_row_t r;
		r = '0;
		unique case (idx)
			4'd0:  r = '{1'b1, ">", 7'd3,  7'd4,  7'd5};
			4'd1:  r = '{1'b0, 8'h00, 7'd0, 7'd6,  7'd7};
			4'd2:  r = '{1'b1, "&", 7'd9,  7'd10, 7'd11};
			4'd3:  r = '{1'b1, "|", 7'd12, 7'd13, 7'd14};
			4'd4:  r = '{1'b0, 8'h00, 7'd0, 7'd15, 7'd16};
			4'd5:  r = '{1'b1, "+", 7'd17, 7'd18, 7'd19};
			4'd6:  r = '{1'b1, "-", 7'd20, 7'd21, 7'd22};
			4'd7:  r = '{1'b0, 8'h00, 7'd0, 7'd23, 7'd24};
			4'd8:  r = '{1'b1, ">", 7'd0,  7'd29, 7'd30};
			4'd9:  r = '{1'b0, 8'h00, 7'd0, 7'd27, 7'd28};
			4'd10: r = '{1'b1, "<", 7'd0,  7'd33, 7'd34};
			4'd11: r = '{1'b0, 8'h00, 7'd0, 7'd31, 7'd32};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Word kind from the first eight bytes (byte i at p[8*i +: 8]) and length
	function automatic logic [6:0] kw_kind(input logic [63:0] p, input logic [4:0] len);
		logic [6:0] r;
		logic       hit;
		r = K_IDENT;
		for (int k = 0; k < N_KW; k++) begin
			hit = (KW_LEN[k] == len);
			for (int i = 0; i < 8; i++) begin
				if ((5'(i) < len) && (p[8*i +: 8] != KW_TEXT[k][63-8*i -: 8]))
					hit = 1'b0;
			end
			if (hit && (r == K_IDENT))
				r = K_KEYWORD0 + 7'(k);
		end
		return r;
	endfunction

	// Typed suffix test on held bytes (byte i at h[8*i +: 8]) of length k
	function automatic logic suffix_match(input logic [39:0] h, input logic [2:0] k,
			input logic frac);
		logic r;
		logic hit;
		r = 1'b0;
		for (int s = 0; s < N_SUF; s++) begin
			hit = (SUF_LEN[s] == k) && (!frac || SUF_FRAC[s]);
			for (int i = 0; i < 5; i++) begin
				if ((3'(i) < k) && (h[8*i +: 8] != SUF_TEXT[s][63-8*i -: 8]))
					hit = 1'b0;
			end
			r = r | hit;
		end
		return r;
	endfunction

endpackage

// ----- rtl/source_text_tokenizer.sv -----
// Source text tokenizer top level: byte queue in front, scanner and result queue behind.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------------
//  bytes   | push / full      | symbol
//  tokens  | empty / pop      | token_kind, is_error, error_code, start_offset,
//          |                  | token_length, start_line, start_column, last_of_run
//
// The scanner takes one byte per cycle unless no byte is there or a full result queue
// holds back its token. A byte that closes a token and has to be looked at again
// (operator, slash, identifier, number end) is scanned once more; a rejected suffix or
// dot replays its held bytes. A token is queued once its run is closed and the result
// queue has room. Reset clears all control state at once; no clearing pass. Either side
// may stall: the front queue keeps taking bytes while the result queue is full.
module source_text_tokenizer
	import tst_pkg::*;
#(
	parameter int POSITION_BITS   = POSITION_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
	parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               symbol,
	output logic                     empty,
	input  logic                     pop,
	output logic [6:0]               token_kind,
	output logic                     is_error,
	output logic [1:0]               error_code,
	output logic [POSITION_BITS-1:0] start_offset,
	output logic [POSITION_BITS-1:0] token_length,
	output logic [POSITION_BITS-1:0] start_line,
	output logic [POSITION_BITS-1:0] start_column,
	output logic                     last_of_run
);

	byte_rec_t rec;
	logic      rec_valid, rec_pop;

	// byte intake and classification
	tst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.symbol    (symbol),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_pop   (rec_pop)
	);

	// scanning and result delivery
	tst_scanner #(
		.POSITION_BITS   (POSITION_BITS),
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
		.LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
	) u_scanner (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec          (rec),
		.rec_pop      (rec_pop),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.is_error     (is_error),
		.error_code   (error_code),
		.start_offset (start_offset),
		.token_length (token_length),
		.start_line   (start_line),
		.start_column (start_column),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- rtl/tst_fifo.sv -----
// Small register queue with full/empty flags and head data on the output.
module tst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// ----- rtl/tst_front.sv -----
// Front end: takes source bytes, tags their character class and queues them.
module tst_front
	import tst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  logic [7:0] symbol,
	output logic      rec_valid,
	output byte_rec_t rec,
	input  logic      rec_pop
);

	byte_rec_t                    rec_in;
	logic [$bits(byte_rec_t)-1:0] rec_raw;
	logic                         q_empty;

	// character class
	always_comb begin
		rec_in.ch  = symbol;
		rec_in.dig = is_digit(symbol);
		rec_in.alp = is_alpha(symbol);
		rec_in.spc = is_space(symbol);
	end

	tst_fifo #(
		.WIDTH ($bits(byte_rec_t)),
		.DEPTH (FRONT_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (rec_in),
		.pop    (rec_pop),
		.empty  (q_empty),
		.rdata  (rec_raw)
	);

	assign rec_valid = !q_empty;
	assign rec       = byte_rec_t'(rec_raw);

endmodule

// ----- rtl/tst_scanner.sv -----
// Back end: scan state machine, suffix lookahead with replay, result queue.
module tst_scanner
	import tst_pkg::*;
#(
	parameter int POSITION_BITS   = POSITION_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
	parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rec_valid,
	input  byte_rec_t                rec,
	output logic                     rec_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic [6:0]               token_kind,
	output logic                     is_error,
	output logic [1:0]               error_code,
	output logic [POSITION_BITS-1:0] start_offset,
	output logic [POSITION_BITS-1:0] token_length,
	output logic [POSITION_BITS-1:0] start_line,
	output logic [POSITION_BITS-1:0] start_column,
	output logic                     last_of_run
);

	localparam int PB  = POSITION_BITS;
	localparam int KML = KEYWORD_MAX_LEN;
	localparam int LAD = LOOKAHEAD_DEPTH;
	localparam int KIW = $clog2(KML);
	localparam int ILW = $clog2(KML + 2);
	localparam int LIW = $clog2(LAD);
	localparam int LCW = $clog2(LAD + 1);
	localparam int TW  = 10 + 4 * PB;

	typedef struct packed {
		logic [PB-1:0] off;
		logic [PB-1:0] line;
		logic [PB-1:0] col;
	} pos_t;

	localparam pos_t POS_RST = '{'0, PB'(1), PB'(1)};

	function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] v, input logic [2:0] k);
		logic [PB:0] s;
		s = {1'b0, v} + (PB+1)'(k);
		return s[PB] ? '1 : s[PB-1:0];
	endfunction

	function automatic pos_t adv(input pos_t p, input logic nl);
		pos_t r;
		r     = p;
		r.off = sat_add(p.off, 3'd1);
		if (nl) begin
			r.line = sat_add(p.line, 3'd1);
			r.col  = PB'(1);
		end else begin
			r.col = sat_add(p.col, 3'd1);
		end
		return r;
	endfunction

	function automatic pos_t adv_k(input pos_t p, input logic [2:0] k);
		pos_t r;
		r     = p;
		r.off = sat_add(p.off, k);
		r.col = sat_add(p.col, k);
		return r;
	endfunction

	// scan state
	scan_mode_t     mode_q, mode_n;
	logic [3:0]     op_q, op_n;
	pos_t           cur_q, cur_n, start_q, start_n;
	logic [7:0]     kp_q [KML];
	logic [7:0]     kp_n [KML];
	logic [7:0]     la_q [LAD];
	logic [7:0]     la_n [LAD];
	logic [LCW-1:0] la_cnt_q, la_cnt_n;
	logic [LCW-1:0] rp_q, rp_n, rcnt_q, rcnt_n;
	logic           frac_q, frac_n;
	logic [ILW-1:0] ilen_q, ilen_n;

	// pending token, held until it is known whether it closes its run
	logic [TW-1:0]  pend_q;
	logic           pend_v_q, pend_done_q;

	// current byte and decode
	logic           rep, avail, go, step_end, opush, ofull;
	logic [7:0]     b;
	logic           b_dig, b_alp, b_spc, b_word;
	logic           emit_c, err_c, consume_c, eof_c, rep_ld;
	logic [6:0]     kind_c;
	logic [1:0]     code_c;
	logic [LCW-1:0] n_c;
	logic [39:0]    held;
	logic [63:0]    pfx;
	logic           sfx_hit;
	logic [6:0]     word_kind;
	op_row_t        row;
	op_lead_t       lead;
	single_t        sk;
	logic [TW-1:0]  tok_c;
	logic [PB-1:0]  tok_so, tok_len, tok_sl, tok_sc;
	logic [TW:0]    ordata;

	// byte source: replayed lookahead first, then the front queue
	assign rep   = (rcnt_q != '0);
	assign avail = rep || rec_valid;
	always_comb begin
		if (rep) begin
			b     = la_q[rp_q[LIW-1:0]];
			b_dig = is_digit(b);
			b_alp = is_alpha(b);
			b_spc = is_space(b);
		end else begin
			b     = rec.ch;
			b_dig = rec.dig;
			b_alp = rec.alp;
			b_spc = rec.spc;
		end
	end
	assign b_word = b_dig || b_alp;

	// held suffix bytes with the current byte in its slot
	always_comb begin
		for (int i = 0; i < 5; i++)
			held[8*i +: 8] = (la_cnt_q == LCW'(i)) ? b : la_q[i];
		for (int i = 0; i < 8; i++)
			pfx[8*i +: 8] = kp_q[i];
	end
	assign n_c       = la_cnt_q + 1'b1;
	assign sfx_hit   = !b_word && suffix_match(held, 3'(la_cnt_q), frac_q);
	assign word_kind = (ilen_q > ILW'(KML)) ? K_IDENT : kw_kind(pfx, 5'(ilen_q));
	assign row       = op_row(op_q);
	assign lead      = op_lead(b);
	assign sk        = single_kind(b);

	// next state for one scan step
	always_comb begin
		mode_n    = mode_q;
		op_n      = op_q;
		cur_n     = cur_q;
		start_n   = start_q;
		kp_n      = kp_q;
		la_n      = la_q;
		la_cnt_n  = la_cnt_q;
		rp_n      = rp_q;
		rcnt_n    = rcnt_q;
		frac_n    = frac_q;
		ilen_n    = ilen_q;
		emit_c    = 1'b0;
		kind_c    = K_EOF;
		err_c     = 1'b0;
		code_c    = ERR_NONE;
		consume_c = 1'b1;
		eof_c     = 1'b0;
		rep_ld    = 1'b0;

		unique case (mode_q) inside
			S_IDLE: begin
				if (b == CH_NUL) begin
					// end of source: emit and restart
					eof_c    = 1'b1;
					emit_c   = 1'b1;
					cur_n    = POS_RST;
					start_n  = POS_RST;
					la_cnt_n = '0;
					frac_n   = 1'b0;
					ilen_n   = '0;
				end else if (b_spc) begin
					cur_n = adv(cur_q, b == CH_LF);
				end else begin
					start_n = cur_q;
					cur_n   = adv(cur_q, 1'b0);
					if (b == CH_SLASH) begin
						mode_n = S_SLASH;
					end else if (b_dig) begin
						frac_n = 1'b0;
						mode_n = S_NUM_INT;
					end else if (b_alp) begin
						kp_n[0] = b;
						ilen_n  = ILW'(1);
						mode_n  = S_IDENT;
					end else if (b == CH_DQUOTE) begin
						mode_n = S_STRING;
					end else if (lead.hit) begin
						op_n   = lead.idx;
						mode_n = S_OP;
					end else if (sk.hit) begin
						emit_c = 1'b1;
						kind_c = sk.kind;
					end else begin
						emit_c = 1'b1;
						err_c  = 1'b1;
						code_c = ERR_UNEXPECTED;
					end
				end
			end
			S_SLASH: begin
				if (b == CH_SLASH) begin
					cur_n  = adv(cur_q, 1'b0);
					mode_n = S_COMMENT;
				end else if (b == CH_EQ) begin
					cur_n  = adv(cur_q, 1'b0);
					emit_c = 1'b1;
					kind_c = K_SLASH_EQ;
				end else begin
					emit_c    = 1'b1;
					kind_c    = K_SLASH;
					consume_c = 1'b0;
				end
			end
			S_COMMENT: begin
				if ((b == CH_LF) || (b == CH_NUL)) begin
					mode_n    = S_IDLE;
					consume_c = 1'b0;
				end else begin
					cur_n = adv(cur_q, 1'b0);
				end
			end
			S_IDENT: begin
				if (b_word) begin
					cur_n = adv(cur_q, 1'b0);
					if (ilen_q < ILW'(KML))
						kp_n[ilen_q[KIW-1:0]] = b;
					if (ilen_q <= ILW'(KML))
						ilen_n = ilen_q + 1'b1;
				end else begin
					emit_c    = 1'b1;
					kind_c    = word_kind;
					consume_c = 1'b0;
				end
			end
			S_STRING: begin
				if (b == CH_NUL) begin
					emit_c    = 1'b1;
					err_c     = 1'b1;
					code_c    = ERR_UNTERM_STR;
					consume_c = 1'b0;
				end else if (b == CH_DQUOTE) begin
					cur_n  = adv(cur_q, 1'b0);
					emit_c = 1'b1;
					kind_c = K_STRING;
				end else begin
					cur_n = adv(cur_q, b == CH_LF);
				end
			end
			S_NUM_INT, S_NUM_FRAC: begin
				if (b_dig) begin
					cur_n = adv(cur_q, 1'b0);
				end else if ((b == CH_DOT) && (mode_q == S_NUM_INT)) begin
					la_n[0]  = b;
					la_cnt_n = LCW'(1);
					mode_n   = S_NUM_DOT;
				end else if (b_alp) begin
					la_n[0]  = b;
					la_cnt_n = LCW'(1);
					mode_n   = S_SUFFIX;
				end else begin
					emit_c    = 1'b1;
					kind_c    = K_NUMBER;
					consume_c = 1'b0;
				end
			end
			S_NUM_DOT: begin
				la_cnt_n = '0;
				if (b_dig) begin
					cur_n  = adv_k(cur_q, 3'd2);
					frac_n = 1'b1;
					mode_n = S_NUM_FRAC;
				end else begin
					// number ends; the dot and this byte go round again
					emit_c  = 1'b1;
					kind_c  = K_NUMBER;
					la_n[1] = b;
					rp_n    = '0;
					rcnt_n  = LCW'(2);
					rep_ld  = 1'b1;
				end
			end
			S_SUFFIX: begin
				la_n[la_cnt_q[LIW-1:0]] = b;
				la_cnt_n                = n_c;
				if (!b_word || (n_c == LCW'(LAD))) begin
					la_cnt_n = '0;
					frac_n   = 1'b0;
					emit_c   = 1'b1;
					rep_ld   = 1'b1;
					if (sfx_hit) begin
						cur_n  = adv_k(cur_q, 3'(la_cnt_q));
						kind_c = K_NUMBER;
						rp_n   = la_cnt_q;
						rcnt_n = n_c;
					end else begin
						err_c  = 1'b1;
						code_c = ERR_BAD_SUFFIX;
						rp_n   = '0;
						rcnt_n = n_c;
					end
				end
			end
			S_OP: begin
				if (row.c1v && (b == row.c1)) begin
					cur_n = adv(cur_q, 1'b0);
					if (row.k1 == 7'd0) begin
						op_n = op_q + 4'd1;
					end else begin
						emit_c = 1'b1;
						kind_c = row.k1;
					end
				end else if (b == CH_EQ) begin
					cur_n  = adv(cur_q, 1'b0);
					emit_c = 1'b1;
					kind_c = row.k2;
				end else begin
					emit_c    = 1'b1;
					kind_c    = row.k0;
					consume_c = 1'b0;
				end
			end
			default: begin
				mode_n    = S_IDLE;
				consume_c = 1'b0;
			end
		endcase

		if (emit_c)
			mode_n = S_IDLE;

		// step the replay pointer
		if (consume_c && rep && !rep_ld) begin
			if ((rp_q + 1'b1) == rcnt_q) begin
				rp_n   = '0;
				rcnt_n = '0;
			end else begin
				rp_n = rp_q + 1'b1;
			end
		end

		// token fields
		if (eof_c) begin
			tok_so  = cur_q.off;
			tok_len = '0;
			tok_sl  = cur_q.line;
			tok_sc  = cur_q.col;
		end else begin
			tok_so  = start_n.off;
			tok_len = cur_n.off - start_n.off;
			tok_sl  = start_n.line;
			tok_sc  = start_n.col;
		end
		tok_c = {kind_c, err_c, code_c, tok_so, tok_len, tok_sl, tok_sc};
	end

	// handshake between scan step, pending token and result queue
	assign go       = avail && !(emit_c && pend_v_q && ofull);
	assign step_end = go && consume_c && (rcnt_n == '0);
	assign opush    = pend_v_q && (pend_done_q || (go && emit_c)) && !ofull;
	assign rec_pop  = go && consume_c && !rep;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= S_IDLE;
			op_q        <= '0;
			cur_q       <= POS_RST;
			start_q     <= POS_RST;
			la_cnt_q    <= '0;
			rp_q        <= '0;
			rcnt_q      <= '0;
			frac_q      <= 1'b0;
			ilen_q      <= '0;
			pend_v_q    <= 1'b0;
			pend_done_q <= 1'b0;
		end else begin
			if (go) begin
				mode_q   <= mode_n;
				op_q     <= op_n;
				cur_q    <= cur_n;
				start_q  <= start_n;
				la_cnt_q <= la_cnt_n;
				rp_q     <= rp_n;
				rcnt_q   <= rcnt_n;
				frac_q   <= frac_n;
				ilen_q   <= ilen_n;
			end
			if (go && emit_c) begin
				pend_v_q    <= 1'b1;
				pend_done_q <= step_end;
			end else if (opush) begin
				pend_v_q    <= 1'b0;
				pend_done_q <= 1'b0;
			end else if (step_end && pend_v_q) begin
				pend_done_q <= 1'b1;
			end
		end
	end

	// byte stores and pending payload
	always_ff @(posedge clk) begin
		if (go) begin
			kp_q <= kp_n;
			la_q <= la_n;
		end
		if (go && emit_c)
			pend_q <= tok_c;
	end

	tst_fifo #(
		.WIDTH (TW + 1),
		.DEPTH (RESULT_DEPTH)
	) u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (opush),
		.full   (ofull),
		.wdata  ({pend_q, pend_done_q}),
		.pop    (pop),
		.empty  (empty),
		.rdata  (ordata)
	);

	assign {token_kind, is_error, error_code, start_offset, token_length,
		start_line, start_column, last_of_run} = ordata;

	// replay pointer stays inside the held bytes
	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q != '0) |-> (rp_q < rcnt_q))
		else $error("replay pointer beyond held bytes");

	// a closed run always has a token behind it
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_done_q |-> pend_v_q)
		else $error("run closed without pending token");

	// suffix collection never overflows the lookahead
	a_suffix_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == S_SUFFIX) |-> ((la_cnt_q != '0) && (la_cnt_q < LCW'(LAD))))
		else $error("suffix count out of range");

	// replay never overlaps a number that is still collecting lookahead
	a_replay_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q != '0) |-> !((mode_q == S_SUFFIX) || (mode_q == S_NUM_DOT)))
		else $error("replay while lookahead is live");

endmodule
